/* rtl/core/bav_pkg.sv */
package bav_pkg;

   // Field and datapath widths
   localparam int VAL_W  = 32;   // signed edited value and limits
   localparam int STEP_W = 16;   // base step
   localparam int FAST_W = 8;    // acceleration factor
   localparam int INC_W  = 32;   // step after up to two accelerations
   localparam int ACC_W  = 40;   // wide signed work width, never overflows
   localparam int CNT_W  = 16;   // hold counters
   localparam int POS_W  = 4;    // menu position
   localparam int IDX_W  = 3;    // register index

   // Hold counter falls back to one above this value
   localparam logic [CNT_W-1:0] COUNT_TOP = 16'hFFFA;

   // Parameter defaults
   localparam int unsigned FIRST_HIT_DEF       = 2;
   localparam int unsigned REPEAT_DELAY_DEF    = 50;
   localparam int unsigned ACCEL_ONE_DELAY_DEF = 200;
   localparam int unsigned ACCEL_TWO_DELAY_DEF = 500;
   localparam int unsigned REPEAT_PERIOD_DEF   = 8;
   localparam int unsigned MODE_COUNT_DEF      = 12;

   // Register indexes
   localparam logic [IDX_W-1:0] CSR_VALUE_MIN     = 3'd0;
   localparam logic [IDX_W-1:0] CSR_VALUE_MAX     = 3'd1;
   localparam logic [IDX_W-1:0] CSR_STEP_SIZE     = 3'd2;
   localparam logic [IDX_W-1:0] CSR_FAST_FACTOR   = 3'd3;
   localparam logic [IDX_W-1:0] CSR_WRAP_ENABLE   = 3'd4;
   localparam logic [IDX_W-1:0] CSR_INITIAL_VALUE = 3'd5;

   // Per-button hold status
   typedef struct packed {
      logic first_press;   // count is one
      logic first_hit;     // count equals the first-hit value
      logic hit;           // first hit or a repeat hit
      logic over_one;      // held past first acceleration threshold
      logic over_two;      // held past second acceleration threshold
   } btn_status_type;

   // Saturate a wide signed value into the 32 bit signed range
   function automatic logic signed [VAL_W-1:0] sat_val(input logic signed [ACC_W-1:0] x);
      logic [ACC_W-VAL_W:0] hi;
      hi = x[ACC_W-1:VAL_W-1];
      if ((&hi) || !(|hi)) begin
         sat_val = x[VAL_W-1:0];
      end else if (x[ACC_W-1]) begin
         sat_val = {1'b1, {(VAL_W-1){1'b0}}};
      end else begin
         sat_val = {1'b0, {(VAL_W-1){1'b1}}};
      end
   endfunction

endpackage

/* rtl/core/bav_button.sv */
module bav_button #(
   parameter int unsigned FIRST_HIT       = bav_pkg::FIRST_HIT_DEF,
   parameter int unsigned REPEAT_DELAY    = bav_pkg::REPEAT_DELAY_DEF,
   parameter int unsigned ACCEL_ONE_DELAY = bav_pkg::ACCEL_ONE_DELAY_DEF,
   parameter int unsigned ACCEL_TWO_DELAY = bav_pkg::ACCEL_TWO_DELAY_DEF,
   parameter int unsigned REPEAT_PERIOD   = bav_pkg::REPEAT_PERIOD_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step_en,
   input  logic                    pressed,
   output bav_pkg::btn_status_type status
);
   import bav_pkg::*;

   localparam int PH_W = (REPEAT_PERIOD > 1) ? $clog2(REPEAT_PERIOD) : 1;
   localparam logic [PH_W-1:0] PH_LAST  = PH_W'(REPEAT_PERIOD - 1);
   localparam logic [PH_W-1:0] PH_AFTER_FALLBACK = PH_W'(1 % REPEAT_PERIOD);

   logic [CNT_W-1:0] count_ff, count_in, base_count;
   logic [PH_W-1:0]  phase_ff, phase_in, base_phase;

   // Advance the hold count; phase tracks count modulo the repeat period
   always_comb begin
      if (count_ff > COUNT_TOP) begin
         base_count = CNT_W'(1);
         base_phase = PH_AFTER_FALLBACK;
      end else begin
         base_count = count_ff;
         base_phase = phase_ff;
      end
      if (pressed) begin
         count_in = base_count + CNT_W'(1);
         phase_in = (base_phase == PH_LAST) ? '0 : base_phase + PH_W'(1);
      end else begin
         count_in = '0;
         phase_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         phase_ff <= '0;
      end else if (step_en) begin
         count_ff <= count_in;
         phase_ff <= phase_in;
      end
   end

   // Decode hold status from the stored count
   always_comb begin
      status.first_press = (count_ff == CNT_W'(1));
      status.first_hit   = (count_ff == CNT_W'(FIRST_HIT));
      status.hit         = status.first_hit ||
                           ((count_ff > CNT_W'(REPEAT_DELAY)) && (phase_ff == '0));
      status.over_one    = (count_ff > CNT_W'(ACCEL_ONE_DELAY));
      status.over_two    = (count_ff > CNT_W'(ACCEL_TWO_DELAY));
   end

endmodule

/* rtl/core/bav_alu.sv */
module bav_alu (
   input  logic signed [bav_pkg::ACC_W-1:0] op_a,
   input  logic signed [bav_pkg::ACC_W-1:0] op_b,
   input  logic                             sub,
   input  logic                             carry_in,
   output logic signed [bav_pkg::ACC_W-1:0] sum
);
   import bav_pkg::*;

   logic [ACC_W-1:0] b_eff;

   // Add a to b or to the complement of b, with carry in
   always_comb begin
      b_eff = sub ? ~op_b : op_b;
      sum   = op_a + b_eff + ACC_W'(carry_in);
   end

endmodule

/* rtl/core/button_autorepeat_value_editor.sv */
// Channel  Direction  Handshake          Word
// req_     in         req_valid/ready    four button levels of one tick
// rsp_     out        rsp_valid/ready    value, position and request flags
// csr_     in         csr_we             register write, index and data
//
// With no up or down hit in an edit position the result goes from decode
// straight to done; with hits it takes two multiply steps, then two or three
// passes of the shared 40 bit adder per direction. req_ready is high only
// while idle, so no new word is taken until the previous result is loaded.
// A waiting result does not block the next word; a second finished result
// holds the sequencer until the first is taken. Reset is synchronous.
module button_autorepeat_value_editor #(
   parameter int unsigned FIRST_HIT       = bav_pkg::FIRST_HIT_DEF,
   parameter int unsigned REPEAT_DELAY    = bav_pkg::REPEAT_DELAY_DEF,
   parameter int unsigned ACCEL_ONE_DELAY = bav_pkg::ACCEL_ONE_DELAY_DEF,
   parameter int unsigned ACCEL_TWO_DELAY = bav_pkg::ACCEL_TWO_DELAY_DEF,
   parameter int unsigned REPEAT_PERIOD   = bav_pkg::REPEAT_PERIOD_DEF,
   parameter int unsigned MODE_COUNT      = bav_pkg::MODE_COUNT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_up_pressed,
   input  logic                              req_down_pressed,
   input  logic                              req_enter_pressed,
   input  logic                              req_accept_pressed,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [bav_pkg::VAL_W-1:0]  rsp_current_value,
   output logic [bav_pkg::POS_W-1:0]         rsp_menu_position,
   output logic                              rsp_display_changed,
   output logic                              rsp_restore_request,
   output logic                              rsp_exit_request,
   input  logic                              csr_we,
   input  logic [bav_pkg::IDX_W-1:0]         csr_index,
   input  logic [bav_pkg::VAL_W-1:0]         csr_wdata
);
   import bav_pkg::*;

   localparam int ST_W = 4;
   localparam logic [ST_W-1:0] S_IDLE   = 4'd0;
   localparam logic [ST_W-1:0] S_DECODE = 4'd1;
   localparam logic [ST_W-1:0] S_MUL1   = 4'd2;
   localparam logic [ST_W-1:0] S_MUL2   = 4'd3;
   localparam logic [ST_W-1:0] S_UP_A   = 4'd4;
   localparam logic [ST_W-1:0] S_UP_B   = 4'd5;
   localparam logic [ST_W-1:0] S_UP_C   = 4'd6;
   localparam logic [ST_W-1:0] S_DN_A   = 4'd7;
   localparam logic [ST_W-1:0] S_DN_B   = 4'd8;
   localparam logic [ST_W-1:0] S_DN_C   = 4'd9;
   localparam logic [ST_W-1:0] S_DONE   = 4'd10;

   localparam logic [POS_W:0] MODE_TOP = (POS_W+1)'(MODE_COUNT);

   // Configuration registers
   logic signed [VAL_W-1:0] min_ff, max_ff;
   logic [STEP_W-1:0]       step_ff;
   logic [FAST_W-1:0]       fast_ff;
   logic                    wrap_ff;

   // Sequencer and datapath
   logic [ST_W-1:0]         state_ff, state_in;
   logic [POS_W-1:0]        pos_ff, pos_in, pos_next;
   logic [POS_W:0]          pos_sum;
   logic signed [VAL_W-1:0] value_ff, value_in;
   logic [INC_W-1:0]        inc_ff, inc_in;
   logic signed [ACC_W-1:0] acc_ff, acc_in;
   logic                    changed_ff, changed_in;
   logic                    restore_ff, restore_in;
   logic                    exit_ff, exit_in;
   logic                    step_en, load_rsp, edit_now, edit_next;
   logic                    accel_one, accel_two;

   logic [INC_W-1:0]          mul_a;
   logic [INC_W+FAST_W-1:0]   product;

   logic signed [ACC_W-1:0] alu_a, alu_b, alu_sum;
   logic                    alu_sub, alu_cin;
   logic signed [ACC_W-1:0] value_ext, inc_ext, min_ext, max_ext;

   btn_status_type up_st, dn_st, en_st, ac_st;

   function automatic logic in_edit(input logic [POS_W-1:0] pos);
      in_edit = (pos != '0) && (({1'b0, pos} + (POS_W+1)'(2)) <= MODE_TOP);
   endfunction

   assign step_en   = req_valid && req_ready;
   assign req_ready = (state_ff == S_IDLE);

   // Hold counters, one per button
   bav_button #(
      .FIRST_HIT(FIRST_HIT), .REPEAT_DELAY(REPEAT_DELAY),
      .ACCEL_ONE_DELAY(ACCEL_ONE_DELAY), .ACCEL_TWO_DELAY(ACCEL_TWO_DELAY),
      .REPEAT_PERIOD(REPEAT_PERIOD)
   ) u_up (.clock(clock), .reset(reset), .step_en(step_en),
           .pressed(req_up_pressed), .status(up_st));

   bav_button #(
      .FIRST_HIT(FIRST_HIT), .REPEAT_DELAY(REPEAT_DELAY),
      .ACCEL_ONE_DELAY(ACCEL_ONE_DELAY), .ACCEL_TWO_DELAY(ACCEL_TWO_DELAY),
      .REPEAT_PERIOD(REPEAT_PERIOD)
   ) u_down (.clock(clock), .reset(reset), .step_en(step_en),
             .pressed(req_down_pressed), .status(dn_st));

   bav_button #(
      .FIRST_HIT(FIRST_HIT), .REPEAT_DELAY(REPEAT_DELAY),
      .ACCEL_ONE_DELAY(ACCEL_ONE_DELAY), .ACCEL_TWO_DELAY(ACCEL_TWO_DELAY),
      .REPEAT_PERIOD(REPEAT_PERIOD)
   ) u_enter (.clock(clock), .reset(reset), .step_en(step_en),
              .pressed(req_enter_pressed), .status(en_st));

   bav_button #(
      .FIRST_HIT(FIRST_HIT), .REPEAT_DELAY(REPEAT_DELAY),
      .ACCEL_ONE_DELAY(ACCEL_ONE_DELAY), .ACCEL_TWO_DELAY(ACCEL_TWO_DELAY),
      .REPEAT_PERIOD(REPEAT_PERIOD)
   ) u_accept (.clock(clock), .reset(reset), .step_en(step_en),
               .pressed(req_accept_pressed), .status(ac_st));

   // Menu position after the enter press, wrapping to one
   always_comb begin
      pos_sum = {1'b0, pos_ff} + (en_st.first_press ? (POS_W+1)'(1) : '0);
      if (pos_sum > MODE_TOP) begin
         pos_next = POS_W'(1);
      end else begin
         pos_next = pos_sum[POS_W-1:0];
      end
      edit_next = in_edit(pos_next);
      edit_now  = in_edit(pos_ff);
   end

   assign accel_one = up_st.over_one || dn_st.over_one;
   assign accel_two = up_st.over_two || dn_st.over_two;

   // Shared multiplier for the step acceleration
   assign mul_a   = (state_ff == S_MUL1) ? INC_W'(step_ff) : inc_ff;
   assign product = (INC_W+FAST_W)'(mul_a) * (INC_W+FAST_W)'(fast_ff);

   // Shared adder
   assign value_ext = ACC_W'(value_ff);
   assign inc_ext   = ACC_W'(inc_ff);
   assign min_ext   = ACC_W'(min_ff);
   assign max_ext   = ACC_W'(max_ff);

   bav_alu u_alu (.op_a(alu_a), .op_b(alu_b), .sub(alu_sub), .carry_in(alu_cin),
                  .sum(alu_sum));

   always_comb begin
      alu_a   = value_ext;
      alu_b   = inc_ext;
      alu_sub = 1'b0;
      alu_cin = 1'b0;
      unique case (state_ff)
         S_UP_B: begin
            // acc - max - 1: not negative when acc is above max
            alu_a = acc_ff;
            alu_b = max_ext;
            alu_sub = 1'b1;
         end
         S_UP_C: begin
            alu_a = min_ext;
            alu_b = acc_ff;
         end
         S_DN_A: begin
            alu_sub = 1'b1;
            alu_cin = 1'b1;
         end
         S_DN_B: begin
            alu_a = acc_ff;
            alu_b = min_ext;
            alu_sub = 1'b1;
            alu_cin = 1'b1;
         end
         S_DN_C: begin
            alu_a = max_ext;
            alu_b = acc_ff;
            alu_cin = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Sequencer
   always_comb begin
      state_in   = state_ff;
      pos_in     = pos_ff;
      value_in   = value_ff;
      inc_in     = inc_ff;
      acc_in     = acc_ff;
      changed_in = changed_ff;
      restore_in = restore_ff;
      exit_in    = exit_ff;
      load_rsp   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (step_en) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            pos_in     = pos_next;
            restore_in = ac_st.first_hit && (({1'b0, pos_next} + (POS_W+1)'(1)) == MODE_TOP);
            exit_in    = ac_st.first_hit && !restore_in;
            changed_in = en_st.first_press || ac_st.first_hit ||
                         (edit_next && (up_st.hit || dn_st.hit));
            state_in   = (edit_next && (up_st.hit || dn_st.hit)) ? S_MUL1 : S_DONE;
         end
         S_MUL1: begin
            inc_in   = accel_one ? product[INC_W-1:0] : INC_W'(step_ff);
            state_in = S_MUL2;
         end
         S_MUL2: begin
            if (accel_two) begin
               inc_in = product[INC_W-1:0];
            end
            state_in = up_st.hit ? S_UP_A : S_DN_A;
         end
         S_UP_A: begin
            acc_in   = alu_sum;
            state_in = S_UP_B;
         end
         S_UP_B: begin
            state_in = dn_st.hit ? S_DN_A : S_DONE;
            if (!alu_sum[ACC_W-1]) begin
               // above max: clamp, or carry the overshoot past min
               if (wrap_ff) begin
                  acc_in   = alu_sum;
                  state_in = S_UP_C;
               end else begin
                  value_in = max_ff;
               end
            end else begin
               value_in = sat_val(acc_ff);
            end
         end
         S_UP_C: begin
            value_in = sat_val(alu_sum);
            state_in = dn_st.hit ? S_DN_A : S_DONE;
         end
         S_DN_A: begin
            acc_in   = alu_sum;
            state_in = S_DN_B;
         end
         S_DN_B: begin
            state_in = S_DONE;
            if (alu_sum[ACC_W-1]) begin
               // below min: clamp, or carry the undershoot below max
               if (wrap_ff) begin
                  acc_in   = alu_sum;
                  state_in = S_DN_C;
               end else begin
                  value_in = min_ff;
               end
            end else begin
               value_in = sat_val(acc_ff);
            end
         end
         S_DN_C: begin
            value_in = sat_val(alu_sum);
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid || rsp_ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control and configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         pos_ff     <= POS_W'(1);
         value_ff   <= '0;
         min_ff     <= '0;
         max_ff     <= VAL_W'(1000);
         step_ff    <= STEP_W'(1);
         fast_ff    <= FAST_W'(10);
         wrap_ff    <= 1'b0;
         rsp_valid  <= 1'b0;
      end else begin
         state_ff <= state_in;
         pos_ff   <= pos_in;
         // Load the edited value on an initial value write
         if (csr_we && (csr_index == CSR_INITIAL_VALUE)) begin
            value_ff <= csr_wdata;
         end else begin
            value_ff <= value_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               CSR_VALUE_MIN:     min_ff  <= csr_wdata;
               CSR_VALUE_MAX:     max_ff  <= csr_wdata;
               CSR_STEP_SIZE:     step_ff <= csr_wdata[STEP_W-1:0];
               CSR_FAST_FACTOR:   fast_ff <= csr_wdata[FAST_W-1:0];
               CSR_WRAP_ENABLE:   wrap_ff <= csr_wdata[0];
               default: begin
               end
            endcase
         end
         if (load_rsp) begin
            rsp_valid <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid <= 1'b0;
         end
      end
   end

   // Datapath and result words
   always_ff @(posedge clock) begin
      inc_ff     <= inc_in;
      acc_ff     <= acc_in;
      changed_ff <= changed_in;
      restore_ff <= restore_in;
      exit_ff    <= exit_in;
      if (load_rsp) begin
         rsp_current_value   <= value_ff;
         rsp_menu_position   <= pos_ff;
         rsp_display_changed <= changed_ff;
         rsp_restore_request <= restore_ff;
         rsp_exit_request    <= exit_ff;
      end
   end

   // Position stays within the menu
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (pos_ff != '0) && ({1'b0, pos_ff} <= MODE_TOP))
      else $error("menu position out of range");

   // Restore and exit never come together
   a_req_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_restore_request && rsp_exit_request))
      else $error("restore and exit both set");

   // Any request marks the display as changed
   a_req_changed: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_restore_request || rsp_exit_request) |-> rsp_display_changed)
      else $error("request without display change");

   // Value arithmetic runs only in an edit position
   a_edit_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_UP_A || state_ff == S_DN_A) |-> edit_now)
      else $error("value step outside edit position");

endmodule
